@@ rtl/core/fcd_pkg.sv @@
// ----------------------------------------------------------------------------
// fcd_pkg: shared types and constants of the framed command decoder
// Byte codes of the frame marks and command letters, and the result codes.
// ----------------------------------------------------------------------------
package fcd_pkg;

	typedef logic [7:0]         byte_t;
	typedef logic [2:0]         cmd_code_t;
	typedef logic signed [12:0] cmd_value_t;
	typedef logic [4:0]         count_t;

	localparam int unsigned FRAME_KEEP = 5;
	localparam count_t      COUNT_MAX  = 5'd21;

	localparam byte_t CH_OPEN  = 8'h3C; // '<'
	localparam byte_t CH_CLOSE = 8'h3E; // '>'
	localparam byte_t CH_ZERO  = 8'h30; // '0'
	localparam byte_t CH_UC_C  = 8'h43;
	localparam byte_t CH_UC_E  = 8'h45;
	localparam byte_t CH_UC_S  = 8'h53;

	localparam byte_t CH_A = 8'h61;
	localparam byte_t CH_B = 8'h62;
	localparam byte_t CH_C = 8'h63;
	localparam byte_t CH_E = 8'h65;
	localparam byte_t CH_F = 8'h66;
	localparam byte_t CH_G = 8'h67;
	localparam byte_t CH_H = 8'h68;
	localparam byte_t CH_I = 8'h69;
	localparam byte_t CH_K = 8'h6B;
	localparam byte_t CH_L = 8'h6C;
	localparam byte_t CH_O = 8'h6F;
	localparam byte_t CH_P = 8'h70;
	localparam byte_t CH_R = 8'h72;
	localparam byte_t CH_S = 8'h73;
	localparam byte_t CH_T = 8'h74;

	localparam cmd_code_t CMD_NONE  = 3'd0;
	localparam cmd_code_t CMD_GO    = 3'd1;
	localparam cmd_code_t CMD_SPEED = 3'd2;
	localparam cmd_code_t CMD_STEER = 3'd3;
	localparam cmd_code_t CMD_BACK  = 3'd4;
	localparam cmd_code_t CMD_LEFT  = 3'd5;
	localparam cmd_code_t CMD_STOP  = 3'd6;
	localparam cmd_code_t CMD_RIGHT = 3'd7;

	// Offset of ('0' * 10 + '0') taken out of the steering sum.
	localparam cmd_value_t STEER_BIAS = 13'sd528;

endpackage

@@ rtl/core/fcd_in_if.sv @@
// ----------------------------------------------------------------------------
// fcd_in_if: received byte channel
// Valid/ready channel that carries one received byte per request.
// ----------------------------------------------------------------------------
interface fcd_in_if;
	logic            valid;
	logic            ready;
	fcd_pkg::byte_t  rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/core/fcd_out_if.sv @@
// ----------------------------------------------------------------------------
// fcd_out_if: decoded command channel
// Valid/ready channel that carries one decoded command per request.
// ----------------------------------------------------------------------------
interface fcd_out_if;
	logic                valid;
	logic                ready;
	fcd_pkg::cmd_code_t  cmd_code;
	fcd_pkg::cmd_value_t cmd_value;

	modport source (output valid, output cmd_code, output cmd_value, input ready);
	modport sink   (input valid, input cmd_code, input cmd_value, output ready);
endinterface

@@ rtl/core/framed_ascii_command_decoder.sv @@
// ----------------------------------------------------------------------------
// framed_ascii_command_decoder: decoder of '<'...'>' framed ASCII commands
// Collects frame bodies and emits one decoded command per closed frame.
// ----------------------------------------------------------------------------
// A byte is taken every cycle in which the result register is free or being
// drained, so the sustained rate is one byte per clock. Each byte passes an
// input register and is then applied to the frame state; a closing '>' then
// loads the result register, so a command passes the input register and then
// the result register. Only a stalled result register holds up input.
module framed_ascii_command_decoder (
	input  logic         clk,
	input  logic         arst_n,
	fcd_in_if.sink       in_ch,
	fcd_out_if.source    out_ch
);
	import fcd_pkg::*;

	logic       valid_s1;
	byte_t      byte_s1;
	logic       in_frame_q;
	count_t     frame_count_q;
	byte_t      frame_bytes_q [FRAME_KEEP];
	logic       out_valid_q;
	cmd_code_t  code_q;
	cmd_value_t value_q;

	logic       advance;
	logic       in_ready;
	logic       close_hit;
	cmd_code_t  dec_code;
	cmd_value_t dec_value;
	logic [11:0] tens_x10;

	assign advance   = !out_valid_q || out_ch.ready;
	assign in_ready  = !valid_s1 || advance;
	assign close_hit = valid_s1 && in_frame_q && (byte_s1 == CH_CLOSE);

	assign in_ch.ready      = in_ready;
	assign out_ch.valid     = out_valid_q;
	assign out_ch.cmd_code  = code_q;
	assign out_ch.cmd_value = value_q;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_ch.valid) begin
			byte_s1 <= in_ch.rx_byte;
		end
	end

	// Frame state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q    <= 1'b0;
			frame_count_q <= '0;
		end else if (valid_s1 && advance) begin
			if (!in_frame_q) begin
				if (byte_s1 == CH_OPEN) begin
					in_frame_q    <= 1'b1;
					frame_count_q <= '0;
				end
			end else if (byte_s1 == CH_CLOSE) begin
				in_frame_q    <= 1'b0;
				frame_count_q <= '0;
			end else if (frame_count_q < COUNT_MAX) begin
				frame_count_q <= frame_count_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < FRAME_KEEP; i++) begin
			if (valid_s1 && advance && in_frame_q && (byte_s1 != CH_CLOSE)
					&& (frame_count_q == count_t'(i))) begin
				frame_bytes_q[i] <= byte_s1;
			end
		end
	end

	// Ten times the tens digit as a shift-add.
	assign tens_x10 = {1'b0, frame_bytes_q[1], 3'b000} + {3'b000, frame_bytes_q[1], 1'b0};

	always_comb begin
		dec_code  = CMD_NONE;
		dec_value = '0;
		case (frame_count_q)
			5'd2: begin
				if (frame_bytes_q[0] == CH_G && frame_bytes_q[1] == CH_O) begin
					dec_code = CMD_GO;
				end
			end
			5'd3: begin
				if (frame_bytes_q[0] == CH_UC_C && frame_bytes_q[2] == CH_UC_E) begin
					dec_code  = CMD_SPEED;
					dec_value = $signed({5'b00000, frame_bytes_q[1]})
						- $signed({5'b00000, CH_ZERO});
				end else if (frame_bytes_q[0] == CH_UC_S) begin
					dec_code  = CMD_STEER;
					dec_value = $signed({1'b0, tens_x10})
						+ $signed({5'b00000, frame_bytes_q[2]}) - STEER_BIAS;
				end
			end
			5'd4: begin
				if (frame_bytes_q[0] == CH_B && frame_bytes_q[1] == CH_A
						&& frame_bytes_q[2] == CH_C && frame_bytes_q[3] == CH_K) begin
					dec_code = CMD_BACK;
				end else if (frame_bytes_q[0] == CH_L && frame_bytes_q[1] == CH_E
						&& frame_bytes_q[2] == CH_F && frame_bytes_q[3] == CH_T) begin
					dec_code = CMD_LEFT;
				end else if (frame_bytes_q[0] == CH_S && frame_bytes_q[1] == CH_T
						&& frame_bytes_q[2] == CH_O && frame_bytes_q[3] == CH_P) begin
					dec_code = CMD_STOP;
				end
			end
			5'd5: begin
				if (frame_bytes_q[0] == CH_R && frame_bytes_q[1] == CH_I
						&& frame_bytes_q[2] == CH_G && frame_bytes_q[3] == CH_H
						&& frame_bytes_q[4] == CH_T) begin
					dec_code = CMD_RIGHT;
				end
			end
			default: begin
				dec_code  = CMD_NONE;
				dec_value = '0;
			end
		endcase
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= close_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && close_hit) begin
			code_q  <= dec_code;
			value_q <= dec_value;
		end
	end

	a_result_from_close: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(close_hit && advance))
		else $error("result appeared without a closing byte");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		frame_count_q <= COUNT_MAX)
		else $error("frame count above its limit");

	a_idle_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> frame_count_q == '0)
		else $error("frame count nonzero while idle");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && code_q != CMD_SPEED && code_q != CMD_STEER |-> value_q == '0)
		else $error("nonzero value on a command without one");

endmodule
